FILE: src/c_subset_lexer_assert.svh
// assertion macros used by the lexer top level
`ifndef C_SUBSET_LEXER_ASSERT_SVH
`define C_SUBSET_LEXER_ASSERT_SVH

// condition holds now, expression holds in the same cycle
`define CSL_ASSERT_NOW(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error("lexer check failed");

// condition holds now, expression holds in the next cycle
`define CSL_ASSERT_NEXT(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error("lexer check failed");

`endif

FILE: src/csl_pkg.sv
// types, constants and lookup functions of the c subset lexer
package csl_pkg;

   localparam int PosBits    = 32;
   localparam int PrefixLen  = 7;
   localparam int MaxResults = 4;
   localparam int CountBits  = 3;

   localparam logic [63:0] NUM_SAT_LIMIT = 64'd1844674407370955161;

   localparam logic [5:0] KIND_NONE   = 6'd0;
   localparam logic [5:0] KIND_IDENT  = 6'd36;
   localparam logic [5:0] KIND_STRING = 6'd37;
   localparam logic [5:0] KIND_NUMBER = 6'd38;
   localparam logic [5:0] KIND_EOF    = 6'd39;
   localparam logic [5:0] KIND_CHAR   = 6'd40;

   localparam logic [2:0] ERR_NONE       = 3'd0;
   localparam logic [2:0] ERR_INVALID    = 3'd1;
   localparam logic [2:0] ERR_OPEN_STR   = 3'd2;
   localparam logic [2:0] ERR_OPEN_CMT   = 3'd3;
   localparam logic [2:0] ERR_BAD_HEX    = 3'd4;

   // keyword text, first character in the low byte
   localparam logic [PrefixLen*8-1:0] KW_TEXT [9] = '{
      56'("nruter"), 56'("fi"), 56'("esle"), 56'("rof"), 56'("elihw"),
      56'("tni"), 56'("rahc"), 56'("foezis"), 56'("tcurts")};
   localparam logic [2:0] KW_LEN [9] = '{3'd6, 3'd2, 3'd4, 3'd3, 3'd5, 3'd3, 3'd4, 3'd6, 3'd6};

   typedef enum logic [3:0] {
      MODE_IDLE, MODE_IDENT, MODE_NUMBER, MODE_PUNCT, MODE_LINE, MODE_BLOCK,
      MODE_STAR, MODE_STRING, MODE_ESC, MODE_OCT, MODE_HEX0, MODE_HEX, MODE_ERROR
   } mode_type;

   typedef struct packed {
      logic [7:0] source_byte;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic [5:0]  token_kind;
      logic [2:0]  error_code;
      logic [31:0] start_offset;
      logic [31:0] token_length;
      logic [31:0] line_number;
      logic [31:0] column_number;
      logic [63:0] token_value;
      logic        last_of_run;
   } rsp_type;

   typedef rsp_type [MaxResults-1:0] rsp_array_type;

   function automatic rsp_type mk_res(logic [5:0] kind, logic [2:0] err,
                                      logic [PosBits-1:0] start, logic [PosBits-1:0] len,
                                      logic [PosBits-1:0] line, logic [PosBits-1:0] col,
                                      logic [63:0] val);
      rsp_type r;
      r.token_kind    = kind;
      r.error_code    = err;
      r.start_offset  = start;
      r.token_length  = len;
      r.line_number   = line;
      r.column_number = col;
      r.token_value   = val;
      r.last_of_run   = 1'b0;
      return r;
   endfunction

   function automatic logic is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_alpha(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   // {found, value}
   function automatic logic [4:0] hex_val(logic [7:0] c);
      logic [7:0] d;
      d = 8'd0;
      if (c >= "0" && c <= "9") begin
         d = c - 8'd48;
         return {1'b1, d[3:0]};
      end
      if (c >= "a" && c <= "f") begin
         d = c - 8'd87;
         return {1'b1, d[3:0]};
      end
      if (c >= "A" && c <= "F") begin
         d = c - 8'd55;
         return {1'b1, d[3:0]};
      end
      return 5'd0;
   endfunction

   // {found, kind}
   function automatic logic [6:0] single_kind(logic [7:0] c);
      unique case (c)
         "[": return {1'b1, 6'd9};
         "]": return {1'b1, 6'd10};
         "(": return {1'b1, 6'd11};
         ")": return {1'b1, 6'd12};
         "{": return {1'b1, 6'd13};
         "}": return {1'b1, 6'd14};
         ",": return {1'b1, 6'd15};
         ".": return {1'b1, 6'd16};
         ";": return {1'b1, 6'd19};
         "*": return {1'b1, 6'd21};
         "%": return {1'b1, 6'd22};
         ":": return {1'b1, 6'd23};
         "&": return {1'b1, 6'd24};
         default: return 7'd0;
      endcase
   endfunction

   function automatic logic [6:0] held_kind(logic [7:0] c);
      unique case (c)
         "-": return {1'b1, 6'd17};
         "+": return {1'b1, 6'd18};
         "/": return {1'b1, 6'd20};
         "!": return {1'b1, 6'd25};
         "=": return {1'b1, 6'd27};
         ">": return {1'b1, 6'd29};
         "<": return {1'b1, 6'd31};
         default: return 7'd0;
      endcase
   endfunction

   function automatic logic [6:0] pair_kind(logic [7:0] a, logic [7:0] b);
      priority if (a == "-" && b == "-") return {1'b1, 6'd34};
      else if (a == "-" && b == ">") return {1'b1, 6'd35};
      else if (a == "+" && b == "+") return {1'b1, 6'd33};
      else if (a == "!" && b == "=") return {1'b1, 6'd26};
      else if (a == "=" && b == "=") return {1'b1, 6'd28};
      else if (a == ">" && b == "=") return {1'b1, 6'd30};
      else if (a == "<" && b == "=") return {1'b1, 6'd32};
      else return 7'd0;
   endfunction

   function automatic logic [5:0] ident_kind(logic [PrefixLen*8-1:0] pre,
                                             logic [PosBits-1:0] len);
      logic [5:0] k;
      k = KIND_IDENT;
      for (int i = 8; i >= 0; i--) begin
         if (len == PosBits'(KW_LEN[i]) && pre == KW_TEXT[i]) k = 6'(i);
      end
      return k;
   endfunction

endpackage

FILE: src/csl_lex.sv
// lexer state registers and the per-byte next state and result logic
module csl_lex (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_fire,
   input  csl_pkg::req_type       in_data,
   output csl_pkg::rsp_array_type res,
   output logic [csl_pkg::CountBits-1:0] res_cnt
);

   localparam int PB = csl_pkg::PosBits;

   csl_pkg::mode_type mode_ff, mode_in;
   logic [7:0]    held_ff, held_in;
   logic [PB-1:0] off_ff, off_in, line_ff, line_in, lso_ff, lso_in;
   logic [PB-1:0] tstart_ff, tstart_in, tline_ff, tline_in, tcol_ff, tcol_in;
   logic [csl_pkg::PrefixLen-1:0][7:0] pre_ff, pre_in;
   logic [63:0]   num_ff, num_in;
   logic [7:0]    acc_ff, acc_in;
   logic [1:0]    ecnt_ff, ecnt_in;

   logic [7:0]    c;
   logic          again;
   logic [PB-1:0] len;
   logic [6:0]    pk, hk, sk;
   logic [4:0]    hv;
   logic [3:0]    d;
   logic [csl_pkg::CountBits-1:0] n;

   always_comb begin
      mode_in = mode_ff; held_in = held_ff; off_in = off_ff; line_in = line_ff;
      lso_in = lso_ff; tstart_in = tstart_ff; tline_in = tline_ff; tcol_in = tcol_ff;
      pre_in = pre_ff; num_in = num_ff; acc_in = acc_ff; ecnt_in = ecnt_ff;
      res = '0;
      n = '0;
      again = 1'b0;
      c = in_data.source_byte;
      len = off_ff - tstart_ff;
      pk = csl_pkg::pair_kind(held_ff, c);
      hk = csl_pkg::held_kind(held_ff);
      sk = csl_pkg::single_kind(c);
      hv = csl_pkg::hex_val(c);
      d = 4'(c - 8'd48);
      if (in_fire && c != 8'd0) begin
         unique case (mode_ff)
            csl_pkg::MODE_IDLE, csl_pkg::MODE_STRING: again = 1'b1;
            csl_pkg::MODE_IDENT: begin
               if (csl_pkg::is_alpha(c) || csl_pkg::is_digit(c)) begin
                  if (len < PB'(csl_pkg::PrefixLen)) pre_in[len[2:0]] = c;
               end else begin
                  res[n[1:0]] = csl_pkg::mk_res(csl_pkg::ident_kind(pre_ff, len),
                     csl_pkg::ERR_NONE, tstart_ff, len, tline_ff, tcol_ff, 64'd0);
                  n = n + 1'b1;
                  mode_in = csl_pkg::MODE_IDLE;
                  again = 1'b1;
               end
            end
            csl_pkg::MODE_NUMBER: begin
               if (csl_pkg::is_digit(c)) begin
                  if (num_ff > csl_pkg::NUM_SAT_LIMIT ||
                      (num_ff == csl_pkg::NUM_SAT_LIMIT && d > 4'd5))
                     num_in = '1;
                  else
                     num_in = (num_ff << 3) + (num_ff << 1) + 64'(d);
               end else begin
                  res[n[1:0]] = csl_pkg::mk_res(csl_pkg::KIND_NUMBER, csl_pkg::ERR_NONE,
                     tstart_ff, len, tline_ff, tcol_ff, num_ff);
                  n = n + 1'b1;
                  mode_in = csl_pkg::MODE_IDLE;
                  again = 1'b1;
               end
            end
            csl_pkg::MODE_PUNCT: begin
               priority if (held_ff == "/" && c == "/") mode_in = csl_pkg::MODE_LINE;
               else if (held_ff == "/" && c == "*") mode_in = csl_pkg::MODE_BLOCK;
               else if (pk[6]) begin
                  res[n[1:0]] = csl_pkg::mk_res(pk[5:0], csl_pkg::ERR_NONE, tstart_ff,
                     len + 1'b1, tline_ff, tcol_ff, 64'd0);
                  n = n + 1'b1;
                  mode_in = csl_pkg::MODE_IDLE;
               end else begin
                  res[n[1:0]] = csl_pkg::mk_res(hk[5:0], csl_pkg::ERR_NONE, tstart_ff, len,
                     tline_ff, tcol_ff, 64'd0);
                  n = n + 1'b1;
                  mode_in = csl_pkg::MODE_IDLE;
                  again = 1'b1;
               end
            end
            csl_pkg::MODE_LINE: begin
               if (c == 8'd10) begin
                  mode_in = csl_pkg::MODE_IDLE;
                  again = 1'b1;
               end
            end
            csl_pkg::MODE_BLOCK: begin
               if (c == "*") mode_in = csl_pkg::MODE_STAR;
               else if (c == 8'd10) begin
                  line_in = line_ff + 1'b1;
                  lso_in = off_ff + 1'b1;
               end
            end
            csl_pkg::MODE_STAR: begin
               if (c == "/") mode_in = csl_pkg::MODE_IDLE;
               else if (c != "*") begin
                  if (c == 8'd10) begin
                     line_in = line_ff + 1'b1;
                     lso_in = off_ff + 1'b1;
                  end
                  mode_in = csl_pkg::MODE_BLOCK;
               end
            end
            csl_pkg::MODE_ESC: begin
               if (c >= "0" && c <= "7") begin
                  acc_in = {5'd0, d[2:0]};
                  ecnt_in = 2'd1;
                  mode_in = csl_pkg::MODE_OCT;
               end else if (c == "x") begin
                  acc_in = 8'd0;
                  ecnt_in = 2'd0;
                  mode_in = csl_pkg::MODE_HEX0;
               end else begin
                  if (c == 8'd10) begin
                     line_in = line_ff + 1'b1;
                     lso_in = off_ff + 1'b1;
                  end
                  res[n[1:0]] = csl_pkg::mk_res(csl_pkg::KIND_CHAR, csl_pkg::ERR_NONE,
                     tstart_ff, '0, tline_ff, tcol_ff,
                     64'((c == "a") ? 8'd7  : (c == "b") ? 8'd8  : (c == "t") ? 8'd9 :
                         (c == "n") ? 8'd10 : (c == "v") ? 8'd11 : (c == "f") ? 8'd12 :
                         (c == "r") ? 8'd13 : (c == "e") ? 8'd27 : c));
                  n = n + 1'b1;
                  mode_in = csl_pkg::MODE_STRING;
               end
            end
            csl_pkg::MODE_OCT: begin
               if (c >= "0" && c <= "7" && ecnt_ff < 2'd3) begin
                  acc_in = {acc_ff[4:0], d[2:0]};
                  ecnt_in = ecnt_ff + 1'b1;
                  if (ecnt_ff == 2'd2) begin
                     res[n[1:0]] = csl_pkg::mk_res(csl_pkg::KIND_CHAR, csl_pkg::ERR_NONE,
                        tstart_ff, '0, tline_ff, tcol_ff, 64'({acc_ff[4:0], d[2:0]}));
                     n = n + 1'b1;
                     mode_in = csl_pkg::MODE_STRING;
                  end
               end else begin
                  res[n[1:0]] = csl_pkg::mk_res(csl_pkg::KIND_CHAR, csl_pkg::ERR_NONE,
                     tstart_ff, '0, tline_ff, tcol_ff, 64'(acc_ff));
                  n = n + 1'b1;
                  mode_in = csl_pkg::MODE_STRING;
                  again = 1'b1;
               end
            end
            csl_pkg::MODE_HEX0: begin
               if (hv[4]) begin
                  acc_in = {4'd0, hv[3:0]};
                  mode_in = csl_pkg::MODE_HEX;
               end else if (c == 8'd10) begin
                  res[n[1:0]] = csl_pkg::mk_res(csl_pkg::KIND_NONE, csl_pkg::ERR_OPEN_STR,
                     tstart_ff, '0, tline_ff, tcol_ff, 64'd0);
                  n = n + 1'b1;
                  mode_in = csl_pkg::MODE_ERROR;
               end else begin
                  res[n[1:0]] = csl_pkg::mk_res(csl_pkg::KIND_NONE, csl_pkg::ERR_BAD_HEX,
                     off_ff, '0, line_ff, off_ff - lso_ff, 64'd0);
                  n = n + 1'b1;
                  mode_in = csl_pkg::MODE_ERROR;
               end
            end
            csl_pkg::MODE_HEX: begin
               if (hv[4]) acc_in = {acc_ff[3:0], hv[3:0]};
               else begin
                  res[n[1:0]] = csl_pkg::mk_res(csl_pkg::KIND_CHAR, csl_pkg::ERR_NONE,
                     tstart_ff, '0, tline_ff, tcol_ff, 64'(acc_ff));
                  n = n + 1'b1;
                  mode_in = csl_pkg::MODE_STRING;
                  again = 1'b1;
               end
            end
            default: ;
         endcase

         // idle and string handling, also once a pending token has been closed
         if (again) begin
            if (mode_in == csl_pkg::MODE_IDLE) begin
               priority if (c == " " || (c >= 8'd9 && c <= 8'd13)) begin
                  if (c == 8'd10) begin
                     line_in = line_ff + 1'b1;
                     lso_in = off_ff + 1'b1;
                  end
               end else if (csl_pkg::is_digit(c)) begin
                  tstart_in = off_ff; tline_in = line_in; tcol_in = off_ff - lso_in;
                  num_in = 64'(d);
                  mode_in = csl_pkg::MODE_NUMBER;
               end else if (c == "\"") begin
                  tstart_in = off_ff; tline_in = line_in; tcol_in = off_ff - lso_in;
                  mode_in = csl_pkg::MODE_STRING;
               end else if (csl_pkg::is_alpha(c)) begin
                  tstart_in = off_ff; tline_in = line_in; tcol_in = off_ff - lso_in;
                  pre_in = '0;
                  pre_in[0] = c;
                  mode_in = csl_pkg::MODE_IDENT;
               end else if (csl_pkg::held_kind(c) != 7'd0) begin
                  tstart_in = off_ff; tline_in = line_in; tcol_in = off_ff - lso_in;
                  held_in = c;
                  mode_in = csl_pkg::MODE_PUNCT;
               end else if (sk[6]) begin
                  res[n[1:0]] = csl_pkg::mk_res(sk[5:0], csl_pkg::ERR_NONE, off_ff, PB'(1),
                     line_in, off_ff - lso_in, 64'd0);
                  n = n + 1'b1;
                  tstart_in = off_ff; tline_in = line_in; tcol_in = off_ff - lso_in;
               end else begin
                  res[n[1:0]] = csl_pkg::mk_res(csl_pkg::KIND_NONE, csl_pkg::ERR_INVALID,
                     off_ff, '0, line_in, off_ff - lso_in, 64'd0);
                  n = n + 1'b1;
                  mode_in = csl_pkg::MODE_ERROR;
               end
            end else if (mode_in == csl_pkg::MODE_STRING) begin
               priority if (c == "\"") begin
                  res[n[1:0]] = csl_pkg::mk_res(csl_pkg::KIND_STRING, csl_pkg::ERR_NONE,
                     tstart_ff, len + 1'b1, tline_ff, tcol_ff, 64'd0);
                  n = n + 1'b1;
                  mode_in = csl_pkg::MODE_IDLE;
               end else if (c == "\\") mode_in = csl_pkg::MODE_ESC;
               else if (c == 8'd10) begin
                  res[n[1:0]] = csl_pkg::mk_res(csl_pkg::KIND_NONE, csl_pkg::ERR_OPEN_STR,
                     tstart_ff, '0, tline_ff, tcol_ff, 64'd0);
                  n = n + 1'b1;
                  mode_in = csl_pkg::MODE_ERROR;
               end else begin
                  res[n[1:0]] = csl_pkg::mk_res(csl_pkg::KIND_CHAR, csl_pkg::ERR_NONE,
                     tstart_ff, '0, tline_ff, tcol_ff, 64'(c));
                  n = n + 1'b1;
               end
            end
         end
         off_in = off_ff + 1'b1;
      end

      // end of input: flush, then eof or the open-construct error, then reset
      if (in_fire && (c == 8'd0 || in_data.end_of_input)) begin
         unique case (mode_in)
            csl_pkg::MODE_IDENT, csl_pkg::MODE_NUMBER, csl_pkg::MODE_PUNCT,
            csl_pkg::MODE_IDLE, csl_pkg::MODE_LINE: begin
               if (mode_in == csl_pkg::MODE_IDENT) begin
                  res[n[1:0]] = csl_pkg::mk_res(
                     csl_pkg::ident_kind(pre_in, off_in - tstart_in),
                     csl_pkg::ERR_NONE, tstart_in, off_in - tstart_in, tline_in, tcol_in,
                     64'd0);
                  n = n + 1'b1;
               end else if (mode_in == csl_pkg::MODE_NUMBER) begin
                  res[n[1:0]] = csl_pkg::mk_res(csl_pkg::KIND_NUMBER, csl_pkg::ERR_NONE,
                     tstart_in, off_in - tstart_in, tline_in, tcol_in, num_in);
                  n = n + 1'b1;
               end else if (mode_in == csl_pkg::MODE_PUNCT) begin
                  res[n[1:0]] = csl_pkg::mk_res(csl_pkg::held_kind(held_in) == 7'd0 ? 6'd0 :
                     6'(csl_pkg::held_kind(held_in)), csl_pkg::ERR_NONE, tstart_in,
                     off_in - tstart_in, tline_in, tcol_in, 64'd0);
                  n = n + 1'b1;
               end
               res[n[1:0]] = csl_pkg::mk_res(csl_pkg::KIND_EOF, csl_pkg::ERR_NONE, off_in,
                  '0, line_in, off_in - lso_in, 64'd0);
               n = n + 1'b1;
            end
            csl_pkg::MODE_BLOCK, csl_pkg::MODE_STAR: begin
               res[n[1:0]] = csl_pkg::mk_res(csl_pkg::KIND_NONE, csl_pkg::ERR_OPEN_CMT,
                  tstart_in, '0, tline_in, tcol_in, 64'd0);
               n = n + 1'b1;
            end
            csl_pkg::MODE_STRING, csl_pkg::MODE_ESC, csl_pkg::MODE_OCT,
            csl_pkg::MODE_HEX0, csl_pkg::MODE_HEX: begin
               res[n[1:0]] = csl_pkg::mk_res(csl_pkg::KIND_NONE, csl_pkg::ERR_OPEN_STR,
                  tstart_in, '0, tline_in, tcol_in, 64'd0);
               n = n + 1'b1;
            end
            default: ;
         endcase
         mode_in = csl_pkg::MODE_IDLE; held_in = '0; off_in = '0; line_in = PB'(1);
         lso_in = '0; tstart_in = '0; tline_in = PB'(1); tcol_in = '0; pre_in = '0;
         num_in = '0; acc_in = '0; ecnt_in = '0;
      end
      res_cnt = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= csl_pkg::MODE_IDLE;
         held_ff <= '0; off_ff <= '0; line_ff <= PB'(1); lso_ff <= '0;
         tstart_ff <= '0; tline_ff <= PB'(1); tcol_ff <= '0; pre_ff <= '0;
         num_ff <= '0; acc_ff <= '0; ecnt_ff <= '0;
      end else begin
         mode_ff <= mode_in;
         held_ff <= held_in; off_ff <= off_in; line_ff <= line_in; lso_ff <= lso_in;
         tstart_ff <= tstart_in; tline_ff <= tline_in; tcol_ff <= tcol_in; pre_ff <= pre_in;
         num_ff <= num_in; acc_ff <= acc_in; ecnt_ff <= ecnt_in;
      end
   end

endmodule

FILE: src/c_subset_lexer.sv
// c subset lexer top level: lexing stage and result buffer
//
//   channel | direction | payload              | accepted when
//   req     | in        | csl_pkg::req_type    | req_valid && req_ready
//   rsp     | out       | csl_pkg::rsp_type    | rsp_valid && rsp_ready
//
// a byte is lexed in the cycle it is accepted; its results land in a four-entry
// result register that drains one result per cycle while rsp_ready is high
// one byte per cycle while each byte gives at most one result and rsp_ready is
// high; a byte with more results holds the request side while the buffer drains
// reset is synchronous and returns the lexer to the start of a new source
// a stalled rsp side holds the buffer and, once it is not draining, the request
module c_subset_lexer (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  csl_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output csl_pkg::rsp_type rsp_data
);

   `include "c_subset_lexer_assert.svh"

   localparam int CB = csl_pkg::CountBits;

   csl_pkg::rsp_array_type lex_res, res_ff, res_in;
   logic [CB-1:0] lex_cnt, num_ff, num_in;
   logic [1:0]    rd_ff, rd_in;
   logic          req_fire, rsp_fire, rsp_last;

   csl_lex u_lex (
      .clock   (clock),
      .reset   (reset),
      .in_fire (req_fire),
      .in_data (req_data),
      .res     (lex_res),
      .res_cnt (lex_cnt)
   );

   assign rsp_valid = num_ff != '0;
   assign rsp_last  = {1'b0, rd_ff} == num_ff - 1'b1;
   assign rsp_fire  = rsp_valid && rsp_ready;
   // the buffer may refill in the cycle its final result is taken
   assign req_ready = !rsp_valid || (rsp_ready && rsp_last);
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      rsp_data = res_ff[rd_ff];
      rsp_data.last_of_run = rsp_last;
   end

   always_comb begin
      res_in = res_ff;
      num_in = num_ff;
      rd_in  = rd_ff;
      if (rsp_fire) begin
         if (rsp_last) begin
            num_in = '0;
            rd_in  = '0;
         end else begin
            rd_in = rd_ff + 1'b1;
         end
      end
      if (req_fire) begin
         res_in = lex_res;
         num_in = lex_cnt;
         rd_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
      if (reset) begin
         num_ff <= '0;
         rd_ff  <= '0;
      end else begin
         num_ff <= num_in;
         rd_ff  <= rd_in;
      end
   end

   `CSL_ASSERT_NOW(a_rd_in_range, rsp_valid, {1'b0, rd_ff} < num_ff)
   `CSL_ASSERT_NOW(a_count_bound, 1'b1, num_ff <= CB'(csl_pkg::MaxResults))
   `CSL_ASSERT_NEXT(a_load_count, req_fire, num_ff == $past(lex_cnt))
   `CSL_ASSERT_NEXT(a_drain_empty, rsp_fire && rsp_last && !req_fire, num_ff == '0)

endmodule

FILE: dv/c_subset_lexer_test.sv
// testbench for the c subset lexer: streams source bytes and checks every token against a model
module c_subset_lexer_test;
   timeunit 1ns;
   timeprecision 1ps;

   // token predictor and queue of expected tokens
   class token_board;
      csl_pkg::mode_type mode;
      logic [7:0] held;
      logic [31:0] offs, line, lstart, tstart, tline, tcol;
      logic [7:0] prefix [7];
      logic [63:0] acc;
      logic [7:0] esc;
      int unsigned esc_cnt;
      csl_pkg::rsp_type exp_tokens [$];
      csl_pkg::rsp_type run [$];
      int unsigned errors, checked, bytes_seen, sources;

      function void clear();
         mode = csl_pkg::MODE_IDLE; held = 0; offs = 0; line = 1; lstart = 0;
         tstart = 0; tline = 1; tcol = 0; acc = 0; esc = 0; esc_cnt = 0;
         foreach (prefix[i]) prefix[i] = 0;
      endfunction

      function void put(logic [5:0] k, logic [2:0] e, logic [31:0] s, logic [31:0] l,
                        logic [31:0] ln, logic [31:0] c, logic [63:0] v);
         csl_pkg::rsp_type r;
         r.token_kind = k; r.error_code = e; r.start_offset = s; r.token_length = l;
         r.line_number = ln; r.column_number = c; r.token_value = v; r.last_of_run = 0;
         if (run.size() < csl_pkg::MaxResults) run.push_back(r);
      endfunction

      function void tok(logic [5:0] k, logic [31:0] l, logic [63:0] v);
         put(k, csl_pkg::ERR_NONE, tstart, l, tline, tcol, v);
      endfunction

      function void chr(logic [7:0] v);
         put(csl_pkg::KIND_CHAR, csl_pkg::ERR_NONE, tstart, 0, tline, tcol, {56'd0, v});
      endfunction

      function void err_at(logic [2:0] e);
         put(csl_pkg::KIND_NONE, e, offs, 0, line, offs - lstart, 0);
         mode = csl_pkg::MODE_ERROR;
      endfunction

      function void err_tok(logic [2:0] e);
         put(csl_pkg::KIND_NONE, e, tstart, 0, tline, tcol, 0);
         mode = csl_pkg::MODE_ERROR;
      endfunction

      function void begin_tok();
         tstart = offs; tline = line; tcol = offs - lstart;
      endfunction

      function void nl();
         line++; lstart = offs + 1;
      endfunction

      function bit alpha(logic [7:0] c);
         return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
      endfunction

      function bit digit(logic [7:0] c);
         return c >= "0" && c <= "9";
      endfunction

      function int hexv(logic [7:0] c);
         if (digit(c)) return c - "0";
         if (c >= "a" && c <= "f") return c - "a" + 10;
         if (c >= "A" && c <= "F") return c - "A" + 10;
         return -1;
      endfunction

      function int one_kind(logic [7:0] c);
         case (c)
            "[": return 9;  "]": return 10; "(": return 11; ")": return 12;
            "{": return 13; "}": return 14; ",": return 15; ".": return 16;
            ";": return 19; "*": return 21; "%": return 22; ":": return 23;
            "&": return 24;
            default: return -1;
         endcase
      endfunction

      function int lead_kind(logic [7:0] c);
         case (c)
            "-": return 17; "+": return 18; "/": return 20; "!": return 25;
            "=": return 27; ">": return 29; "<": return 31;
            default: return -1;
         endcase
      endfunction

      function int two_kind(logic [7:0] a, logic [7:0] b);
         if (a == "-" && b == "-") return 34;
         if (a == "-" && b == ">") return 35;
         if (a == "+" && b == "+") return 33;
         if (b == "=") begin
            if (a == "!") return 26;
            if (a == "=") return 28;
            if (a == ">") return 30;
            if (a == "<") return 32;
         end
         return -1;
      endfunction

      function logic [5:0] word_kind();
         string words [9] = '{"return", "if", "else", "for", "while", "int", "char",
                              "sizeof", "struct"};
         logic [31:0] n;
         bit same;
         n = offs - tstart;
         for (int k = 0; k < 9; k++) begin
            if (n != words[k].len()) continue;
            same = 1;
            for (int i = 0; i < words[k].len(); i++)
               if (prefix[i] != words[k][i]) same = 0;
            if (same) return 6'(k);
         end
         return csl_pkg::KIND_IDENT;
      endfunction

      function void flush();
         if (mode == csl_pkg::MODE_IDENT) tok(word_kind(), offs - tstart, 0);
         else if (mode == csl_pkg::MODE_NUMBER) tok(csl_pkg::KIND_NUMBER, offs - tstart, acc);
         else if (mode == csl_pkg::MODE_PUNCT) tok(6'(lead_kind(held)), offs - tstart, 0);
         mode = csl_pkg::MODE_IDLE;
      endfunction

      function void start_byte(logic [7:0] c);
         int k;
         if (c == " " || (c >= 9 && c <= 13)) begin
            if (c == 8'd10) nl();
         end else if (digit(c)) begin
            begin_tok(); acc = c - "0"; mode = csl_pkg::MODE_NUMBER;
         end else if (c == "\"") begin
            begin_tok(); mode = csl_pkg::MODE_STRING;
         end else if (alpha(c)) begin
            begin_tok();
            foreach (prefix[i]) prefix[i] = 0;
            prefix[0] = c; mode = csl_pkg::MODE_IDENT;
         end else if (lead_kind(c) >= 0) begin
            begin_tok(); held = c; mode = csl_pkg::MODE_PUNCT;
         end else begin
            k = one_kind(c);
            if (k >= 0) begin
               begin_tok(); tok(6'(k), 1, 0);
            end else err_at(csl_pkg::ERR_INVALID);
         end
      endfunction

      function void escaped(logic [7:0] c);
         logic [7:0] v;
         v = c;
         if (c >= "0" && c <= "7") begin
            esc = c - "0"; esc_cnt = 1; mode = csl_pkg::MODE_OCT; return;
         end
         if (c == "x") begin
            esc = 0; esc_cnt = 0; mode = csl_pkg::MODE_HEX0; return;
         end
         case (c)
            "a": v = 7;  "b": v = 8;  "t": v = 9;  "n": v = 10;
            "v": v = 11; "f": v = 12; "r": v = 13; "e": v = 27;
            default: ;
         endcase
         if (c == 8'd10) nl();
         chr(v);
         mode = csl_pkg::MODE_STRING;
      endfunction

      function void lex(logic [7:0] c);
         int k;
         logic [31:0] n;
         forever begin
            case (mode)
               csl_pkg::MODE_IDLE: begin start_byte(c); return; end
               csl_pkg::MODE_IDENT: begin
                  if (alpha(c) || digit(c)) begin
                     n = offs - tstart;
                     if (n < 7) prefix[n] = c;
                     return;
                  end
                  flush();
               end
               csl_pkg::MODE_NUMBER: begin
                  if (digit(c)) begin
                     if (acc > csl_pkg::NUM_SAT_LIMIT ||
                         (acc == csl_pkg::NUM_SAT_LIMIT && c > "5"))
                        acc = '1;
                     else acc = acc * 10 + (c - "0");
                     return;
                  end
                  flush();
               end
               csl_pkg::MODE_PUNCT: begin
                  if (held == "/" && c == "/") begin mode = csl_pkg::MODE_LINE; return; end
                  if (held == "/" && c == "*") begin mode = csl_pkg::MODE_BLOCK; return; end
                  k = two_kind(held, c);
                  if (k >= 0) begin
                     tok(6'(k), offs - tstart + 1, 0); mode = csl_pkg::MODE_IDLE; return;
                  end
                  flush();
               end
               csl_pkg::MODE_LINE: begin
                  if (c != 8'd10) return;
                  mode = csl_pkg::MODE_IDLE;
               end
               csl_pkg::MODE_BLOCK: begin
                  if (c == "*") mode = csl_pkg::MODE_STAR;
                  else if (c == 8'd10) nl();
                  return;
               end
               csl_pkg::MODE_STAR: begin
                  if (c == "/") mode = csl_pkg::MODE_IDLE;
                  else if (c != "*") begin
                     if (c == 8'd10) nl();
                     mode = csl_pkg::MODE_BLOCK;
                  end
                  return;
               end
               csl_pkg::MODE_STRING: begin
                  if (c == "\"") begin
                     tok(csl_pkg::KIND_STRING, offs - tstart + 1, 0);
                     mode = csl_pkg::MODE_IDLE;
                  end else if (c == "\\") mode = csl_pkg::MODE_ESC;
                  else if (c == 8'd10) err_tok(csl_pkg::ERR_OPEN_STR);
                  else chr(c);
                  return;
               end
               csl_pkg::MODE_ESC: begin escaped(c); return; end
               csl_pkg::MODE_OCT: begin
                  if (c >= "0" && c <= "7" && esc_cnt < 3) begin
                     esc = (esc << 3) + (c - "0");
                     esc_cnt++;
                     if (esc_cnt >= 3) begin chr(esc); mode = csl_pkg::MODE_STRING; end
                     return;
                  end
                  chr(esc); mode = csl_pkg::MODE_STRING;
               end
               csl_pkg::MODE_HEX0: begin
                  k = hexv(c);
                  if (k >= 0) begin esc = 8'(k); mode = csl_pkg::MODE_HEX; end
                  else if (c == 8'd10) err_tok(csl_pkg::ERR_OPEN_STR);
                  else err_at(csl_pkg::ERR_BAD_HEX);
                  return;
               end
               csl_pkg::MODE_HEX: begin
                  k = hexv(c);
                  if (k >= 0) begin esc = (esc << 4) + 8'(k); return; end
                  chr(esc); mode = csl_pkg::MODE_STRING;
               end
               default: return;
            endcase
         end
      endfunction

      function void end_source();
         case (mode)
            csl_pkg::MODE_IDENT, csl_pkg::MODE_NUMBER, csl_pkg::MODE_PUNCT,
            csl_pkg::MODE_IDLE, csl_pkg::MODE_LINE: begin
               flush();
               put(csl_pkg::KIND_EOF, csl_pkg::ERR_NONE, offs, 0, line, offs - lstart, 0);
            end
            csl_pkg::MODE_BLOCK, csl_pkg::MODE_STAR: err_tok(csl_pkg::ERR_OPEN_CMT);
            csl_pkg::MODE_ERROR: ;
            default: err_tok(csl_pkg::ERR_OPEN_STR);
         endcase
         sources++;
         clear();
      endfunction

      function void note_request(csl_pkg::req_type q);
         run.delete();
         bytes_seen++;
         if (q.source_byte != 0) begin
            lex(q.source_byte);
            offs++;
         end
         if (q.source_byte == 0 || q.end_of_input) end_source();
         if (run.size() > 0) run[run.size() - 1].last_of_run = 1;
         foreach (run[i]) exp_tokens.push_back(run[i]);
      endfunction

      task report(string what, logic [63:0] got, logic [63:0] want);
         $display("mismatch on token %0d: %s got %0h expected %0h", checked, what, got, want);
         errors++;
      endtask

      task check_token(csl_pkg::rsp_type got);
         csl_pkg::rsp_type w;
         if (exp_tokens.size() == 0) begin
            report("unexpected token kind", got.token_kind, 0);
            return;
         end
         w = exp_tokens.pop_front();
         if (got.token_kind !== w.token_kind) report("kind", got.token_kind, w.token_kind);
         if (got.error_code !== w.error_code) report("error", got.error_code, w.error_code);
         if (got.start_offset !== w.start_offset)
            report("offset", got.start_offset, w.start_offset);
         if (got.token_length !== w.token_length)
            report("length", got.token_length, w.token_length);
         if (got.line_number !== w.line_number) report("line", got.line_number, w.line_number);
         if (got.column_number !== w.column_number)
            report("column", got.column_number, w.column_number);
         if (got.token_value !== w.token_value) report("value", got.token_value, w.token_value);
         if (got.last_of_run !== w.last_of_run) report("last", got.last_of_run, w.last_of_run);
         checked++;
      endtask
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   csl_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   csl_pkg::rsp_type rsp_data;

   token_board board = new();
   bit calm;
   int unsigned sent;

   c_subset_lexer u_dut (.*);

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   initial begin
      #4ms;
      $display("CHECK FAILED");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) board.note_request(req_data);
      if (!reset && rsp_valid && rsp_ready) board.check_token(rsp_data);
   end

   always @(negedge clock) rsp_ready <= calm || $urandom_range(99) >= 37;

   // one byte; valid stays up across back-to-back requests unless a random gap drops it
   task send_byte(logic [7:0] b, logic last = 0);
      while (!calm && $urandom_range(99) < 37) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_data <= '{source_byte: b, end_of_input: last};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent++;
      @(negedge clock);
   endtask

   task send_text(string s, bit close = 1);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], close && i == s.len() - 1);
   endtask

   function string piece();
      string p [] = '{"return", "if", "else", "for", "while", "int", "char", "sizeof",
         "struct", "returnx", "whilez", "_a9", "X", "0", "18446744073709551615",
         "99999999999999999999", "42", "[", "]", "(", ")", "{", "}", ",", ".", ";", "*",
         "%", ":", "&", "-", "+", "/", "!", "=", ">", "<", "!=", "==", ">=", "<=", "++",
         "--", "->", " ", "\t", "\n", "\r", "\v", "\f", "// c\n", "/* a*\n**/",
         "\"ab\"", "\"\\101\\7z\"", "\"\\x4142g\"", "\"\\n\\e\\q\\\n\"", "\"\\1234\""};
      string s;
      int k;
      k = $urandom_range(p.size() - 1);
      s = p[k];
      if ($urandom_range(9) == 0) s = {s, string'(byte'($urandom_range(1, 255)))};
      return s;
   endfunction

   initial begin
      string s;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      board.clear();
      calm = 0;
      // directed sources
      send_text("return if else for while int char sizeof struct structs x\n");
      send_text("[](){},.;*%:& - + / ! = > < != == >= <= ++ -- -> a-b");
      send_text("0 18446744073709551615 18446744073709551616 7");
      send_text("\"a\\101\\x41ffz\\x\\t\\n\\e\\\\\\\n\\Q\\7\"");
      send_byte("a"); send_byte(8'd0);
      send_text("\"abc\n\" more");
      send_text("/* open"); send_text("\"open"); send_text("// fine");
      send_text("\"\\xg\" junk"); send_text("@ $ ~");
      send_byte(8'hff); send_byte(8'd0);
      send_byte(8'h80, 1); send_byte(8'd0); send_byte("/", 1);
      while (sent < 430) begin
         if (sent > 290 && sent < 370) calm = 1; else calm = 0;
         s = "";
         repeat ($urandom_range(1, 6)) s = {s, piece(), " "};
         if ($urandom_range(3) == 0) send_text(s, 0);
         else send_text(s);
         if ($urandom_range(4) == 0) send_byte(8'($urandom_range(1, 255)), $urandom_range(1));
      end
      calm = 0;
      send_byte(8'd0);
      req_valid <= 0;
      while (board.exp_tokens.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("sent %0d bytes over %0d sources, checked %0d tokens",
               board.bytes_seen, board.sources, board.checked);
      if (board.errors == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end
endmodule

FILE: files.f
+incdir+src
src/csl_pkg.sv
src/csl_lex.sv
src/c_subset_lexer.sv
dv/c_subset_lexer_test.sv
